// ----- sv/rmhl_pkg.sv -----
`default_nettype none

package rmhl_pkg;

    // Window geometry
    localparam int WINDOW_LEN = 5;
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // Field widths
    localparam int RANGE_W  = 16;
    localparam int THR_W    = 15;
    localparam int DWELL_W  = 4;
    localparam int GONE_W   = 16;
    localparam int TIME_W   = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELOCK_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_NEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_NEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_GONE  = 3'd4;

    // Reset values
    localparam logic [THR_W-1:0]   UNLOCK_THR_RST = 15'd100;
    localparam logic [THR_W-1:0]   RELOCK_THR_RST = 15'd250;
    localparam logic [DWELL_W-1:0] NEAR_NEED_RST  = 4'd2;
    localparam logic [DWELL_W-1:0] FAR_NEED_RST   = 4'd3;
    localparam logic [GONE_W-1:0]  PEER_GONE_RST  = 16'd1500;

    localparam logic [DWELL_W-1:0] CNT_MAX = 4'd15;

    typedef logic signed [RANGE_W-1:0] t_range;
    typedef t_range [WINDOW_LEN-1:0] t_window;

    typedef struct packed {
        logic [THR_W-1:0]   unlock_thr;
        logic [THR_W-1:0]   relock_thr;
        logic [DWELL_W-1:0] near_need;
        logic [DWELL_W-1:0] far_need;
        logic [GONE_W-1:0]  peer_gone;
    } t_cfg;

    function automatic logic [DWELL_W-1:0] sat_inc(input logic [DWELL_W-1:0] c);
        sat_inc = (c >= CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rmhl_cfg.sv -----
`default_nettype none

module rmhl_cfg (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    input  wire  [rmhl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [rmhl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output rmhl_pkg::t_cfg                        o_cfg
);

    rmhl_pkg::t_cfg r_cfg;

    // Always ready; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_thr <= rmhl_pkg::UNLOCK_THR_RST;
            r_cfg.relock_thr <= rmhl_pkg::RELOCK_THR_RST;
            r_cfg.near_need  <= rmhl_pkg::NEAR_NEED_RST;
            r_cfg.far_need   <= rmhl_pkg::FAR_NEED_RST;
            r_cfg.peer_gone  <= rmhl_pkg::PEER_GONE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rmhl_pkg::REG_UNLOCK_THR: begin
                    r_cfg.unlock_thr <= i_cfg_data[rmhl_pkg::THR_W-1:0];
                end
                rmhl_pkg::REG_RELOCK_THR: begin
                    r_cfg.relock_thr <= i_cfg_data[rmhl_pkg::THR_W-1:0];
                end
                rmhl_pkg::REG_NEAR_NEED: begin
                    r_cfg.near_need <= i_cfg_data[rmhl_pkg::DWELL_W-1:0];
                end
                rmhl_pkg::REG_FAR_NEED: begin
                    r_cfg.far_need <= i_cfg_data[rmhl_pkg::DWELL_W-1:0];
                end
                rmhl_pkg::REG_PEER_GONE: begin
                    r_cfg.peer_gone <= i_cfg_data[rmhl_pkg::GONE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/rmhl_median.sv -----
`default_nettype none

// Upper median of the filled entries by rank counting.
// Filled entries are always indexes 0 .. fill-1.
module rmhl_median (
    input  wire  rmhl_pkg::t_window           i_win,
    input  wire  [rmhl_pkg::FILL_W-1:0]       i_fill,
    output rmhl_pkg::t_range                  o_median
);

    always_comb begin
        logic [rmhl_pkg::FILL_W-1:0] rank;
        logic                        below;
        o_median = '0;
        for (int i = 0; i < rmhl_pkg::WINDOW_LEN; i++) begin
            rank = '0;
            for (int j = 0; j < rmhl_pkg::WINDOW_LEN; j++) begin
                // ties broken by index so ranks are unique
                below = ($signed(i_win[j]) < $signed(i_win[i])) ||
                        ((i_win[j] == i_win[i]) && (j < i));
                if ((j != i) && (rmhl_pkg::FILL_W'(j) < i_fill) && below) begin
                    rank = rank + 1'b1;
                end
            end
            if ((rmhl_pkg::FILL_W'(i) < i_fill) && (rank == (i_fill >> 1))) begin
                o_median = o_median | i_win[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/range_median_hysteresis_lock.sv -----
// Datapath: a wake taken is held in the input register, then passes through the median
//   network and dwell logic into the result register.
// Throughput: one wake per cycle, sustained, while results are taken.
// Reset: synchronous, active low; bolt locked, no peer, window empty, counters and
//   activity time zero, configuration at its defaults. Window contents are not reset.
`default_nettype none

module range_median_hysteresis_lock (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [rmhl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rmhl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // wake channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_activity_seen,
    input  wire                                 i_range_trusted,
    input  wire  signed [rmhl_pkg::RANGE_W-1:0] i_range_cm,
    input  wire  [rmhl_pkg::TIME_W-1:0]         i_now_ms,
    // result channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_drive_unlock,
    output logic                                o_drive_lock,
    output logic                                o_grant_notify,
    output logic                                o_secured_notify,
    output logic signed [rmhl_pkg::RANGE_W-1:0] o_median_cm,
    output logic                                o_bolt_locked
);

    rmhl_pkg::t_cfg w_cfg;

    // Register file takes every transfer at once.
    assign o_cfg_ready = 1'b1;

    rmhl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                              r_in_valid;
    logic                              r_in_act;
    logic                              r_in_trust;
    rmhl_pkg::t_range                  r_in_cm;
    logic [rmhl_pkg::TIME_W-1:0]       r_in_now;

    logic                              w_advance;

    // The wake in the input register moves on whenever the result slot is
    // free or is being emptied this cycle; only then is the state updated.
    assign w_advance  = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_act   <= i_activity_seen;
            r_in_trust <= i_range_trusted;
            r_in_cm    <= i_range_cm;
            r_in_now   <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic                              r_locked;
    logic                              r_present;
    logic [rmhl_pkg::FILL_W-1:0]       r_fill;
    logic [rmhl_pkg::POS_W-1:0]        r_pos;
    logic [rmhl_pkg::DWELL_W-1:0]      r_near;
    logic [rmhl_pkg::DWELL_W-1:0]      r_far;
    logic [rmhl_pkg::TIME_W-1:0]       r_last;
    rmhl_pkg::t_window                 r_window;

    logic                              n_locked;
    logic                              n_present;
    logic [rmhl_pkg::FILL_W-1:0]       n_fill;
    logic [rmhl_pkg::POS_W-1:0]        n_pos;
    logic [rmhl_pkg::DWELL_W-1:0]      n_near;
    logic [rmhl_pkg::DWELL_W-1:0]      n_far;
    logic [rmhl_pkg::TIME_W-1:0]       n_last;
    rmhl_pkg::t_window                 n_window;

    logic                              w_trusted;
    logic [rmhl_pkg::FILL_W-1:0]       w_fill_push;
    rmhl_pkg::t_range                  w_median;
    logic [rmhl_pkg::TIME_W-1:0]       w_silence;
    logic                              w_gone;

    logic                              n_unlock;
    logic                              n_lock;
    logic                              n_grant;
    logic                              n_secured;
    rmhl_pkg::t_range                  n_median;

    // Trust only counts on an active wake.
    assign w_trusted = r_in_act && r_in_trust;

    // Window as it stands after this wake's sample is written in.
    always_comb begin
        for (int k = 0; k < rmhl_pkg::WINDOW_LEN; k++) begin
            if (w_trusted && (r_pos == rmhl_pkg::POS_W'(k))) begin
                n_window[k] = r_in_cm;
            end else begin
                n_window[k] = r_window[k];
            end
        end
    end

    assign w_fill_push = (r_fill < rmhl_pkg::FILL_W'(rmhl_pkg::WINDOW_LEN)) ?
                         r_fill + 1'b1 : r_fill;

    rmhl_median u_median (
        .i_win    (n_window),
        .i_fill   (w_fill_push),
        .o_median (w_median)
    );

    // Silence since the last active wake, modulo 2^48; an active wake is zero.
    assign w_silence = r_in_act ? '0 : (r_in_now - r_last);

    always_comb begin
        logic                         locked_mid;
        logic                         present_mid;
        logic [rmhl_pkg::DWELL_W-1:0] near_inc;
        logic [rmhl_pkg::DWELL_W-1:0] far_inc;

        n_unlock  = 1'b0;
        n_lock    = 1'b0;
        n_grant   = 1'b0;
        n_secured = 1'b0;
        n_median  = '0;
        n_near    = r_near;
        n_far     = r_far;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_last    = r_in_act ? r_in_now : r_last;
        near_inc  = rmhl_pkg::sat_inc(r_near);
        far_inc   = rmhl_pkg::sat_inc(r_far);
        locked_mid  = r_locked;
        present_mid = r_present;

        if (w_trusted) begin
            // first trusted range of an approach
            n_grant     = !r_present;
            present_mid = 1'b1;
            n_fill      = w_fill_push;
            n_pos = (r_pos == rmhl_pkg::POS_W'(rmhl_pkg::WINDOW_LEN - 1)) ?
                    '0 : r_pos + 1'b1;
            n_median    = w_median;

            // Hysteresis band: compared as signed, so negative medians are near.
            if (w_median <= $signed({1'b0, w_cfg.unlock_thr})) begin
                n_far = '0;
                if (r_locked) begin
                    n_near = near_inc;
                    if (near_inc >= w_cfg.near_need) begin
                        n_unlock   = 1'b1;
                        locked_mid = 1'b0;
                    end
                end
            end else if (w_median >= $signed({1'b0, w_cfg.relock_thr})) begin
                n_near = '0;
                if (!r_locked) begin
                    n_far = far_inc;
                    if (far_inc >= w_cfg.far_need) begin
                        n_lock     = 1'b1;
                        locked_mid = 1'b1;
                    end
                end
            end else begin
                // dead band
                n_near = '0;
                n_far  = '0;
            end
        end

        w_gone    = present_mid &&
                    (w_silence >= {{(rmhl_pkg::TIME_W - rmhl_pkg::GONE_W){1'b0}},
                                   w_cfg.peer_gone});
        n_locked  = locked_mid;
        n_present = present_mid;

        // Peer gone: relock if open, report secured, start a fresh approach.
        if (w_gone) begin
            if (!locked_mid) begin
                n_lock   = 1'b1;
                n_locked = 1'b1;
            end
            n_secured = 1'b1;
            n_present = 1'b0;
            n_fill    = '0;
            n_pos     = '0;
            n_near    = '0;
            n_far     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked  <= 1'b1;
            r_present <= 1'b0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_near    <= '0;
            r_far     <= '0;
            r_last    <= '0;
        end else if (w_advance) begin
            r_locked  <= n_locked;
            r_present <= n_present;
            r_fill    <= n_fill;
            r_pos     <= n_pos;
            r_near    <= n_near;
            r_far     <= n_far;
            r_last    <= n_last;
        end
    end

    // Window storage: no reset, entries are read only once written.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_window <= n_window;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_advance) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_drive_unlock   <= n_unlock;
            o_drive_lock     <= n_lock;
            o_grant_notify   <= n_grant;
            o_secured_notify <= n_secured;
            o_median_cm      <= n_median;
            o_bolt_locked    <= n_locked;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= rmhl_pkg::FILL_W'(rmhl_pkg::WINDOW_LEN))
        else $error("window fill beyond window length");

    a_gone_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_gone) |=> (r_fill == '0 && r_near == '0 && r_far == '0 &&
                                   !r_present && r_locked))
        else $error("peer-gone transfer left approach state behind");

    a_secured_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_secured_notify) |-> o_bolt_locked)
        else $error("secured reported with bolt open");

    a_unlock_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_unlock && !o_drive_lock) |-> !o_bolt_locked)
        else $error("unlock pulse but bolt shown locked");

endmodule

`default_nettype wire

// ----- tb/tb_range_median_hysteresis_lock.sv -----
`timescale 1ns / 1ps

module tb_range_median_hysteresis_lock;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int IDLE_PCT        = 31;   // chance of a gap before a transfer / a stalled cycle
    localparam int SETTLE_CYCLES   = 8;    // result path is two registers deep, plus margin
    localparam int PHASES          = 8;    // register settings swept by the random part
    localparam int WAKES_PER_PHASE = 150;
    localparam int QUIET_PHASE     = 5;    // phase with back-to-back transfers on both sides

    // indexes outside the register map; writes to them must be dropped
    localparam logic [rmhl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [rmhl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic {ROW_WAKE, ROW_REG} t_row_kind;
    typedef enum int {ZONE_NEAR, ZONE_FAR, ZONE_DEAD, ZONE_WILD} t_zone;

    // one result transfer, field for field as on the ports
    typedef struct packed {
        logic                                drive_unlock;
        logic                                drive_lock;
        logic                                grant;
        logic                                secured;
        logic signed [rmhl_pkg::RANGE_W-1:0] median_cm;
        logic                                bolt_locked;
    } t_bolt_report;

    // opening script: a wake or a register write, with an optional hand-typed answer
    typedef struct packed {
        t_row_kind                           kind;
        logic                                act;
        logic                                trust;
        logic signed [rmhl_pkg::RANGE_W-1:0] cm;
        logic [rmhl_pkg::TIME_W-1:0]         now;
        logic [rmhl_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [rmhl_pkg::CFG_DATA_W-1:0]     reg_data;
        logic                                typed;
        t_bolt_report                        want;
    } t_script_row;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_cfg_valid     = 1'b0;
    logic                                o_cfg_ready;
    logic [rmhl_pkg::CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic [rmhl_pkg::CFG_DATA_W-1:0]     i_cfg_data      = '0;
    logic                                i_in_valid      = 1'b0;
    logic                                o_in_ready;
    logic                                i_activity_seen = 1'b0;
    logic                                i_range_trusted = 1'b0;
    logic signed [rmhl_pkg::RANGE_W-1:0] i_range_cm      = '0;
    logic [rmhl_pkg::TIME_W-1:0]         i_now_ms        = '0;
    logic                                o_out_valid;
    logic                                i_out_ready     = 1'b0;
    logic                                o_drive_unlock;
    logic                                o_drive_lock;
    logic                                o_grant_notify;
    logic                                o_secured_notify;
    logic signed [rmhl_pkg::RANGE_W-1:0] o_median_cm;
    logic                                o_bolt_locked;

    range_median_hysteresis_lock dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_activity_seen  (i_activity_seen),
        .i_range_trusted  (i_range_trusted),
        .i_range_cm       (i_range_cm),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_unlock   (o_drive_unlock),
        .o_drive_lock     (o_drive_lock),
        .o_grant_notify   (o_grant_notify),
        .o_secured_notify (o_secured_notify),
        .o_median_cm      (o_median_cm),
        .o_bolt_locked    (o_bolt_locked)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the controller: registers and state, updated per transfer
    // ------------------------------------------------------------------
    rmhl_pkg::t_cfg                      shadow_cfg;
    logic                                ctl_locked;
    logic                                peer_present;
    logic signed [rmhl_pkg::RANGE_W-1:0] ring_cm [rmhl_pkg::WINDOW_LEN];
    int                                  ring_fill;
    int                                  ring_pos;
    int                                  near_run;
    int                                  far_run;
    logic [rmhl_pkg::TIME_W-1:0]         last_active_ms;

    t_bolt_report awaited_reports[$];   // predicted results, oldest first
    logic         no_gaps = 1'b0;       // both sides run flat out while set

    int mismatches      = 0;
    int wakes_sent      = 0;
    int reports_checked = 0;
    int unlock_pulses   = 0;
    int lock_pulses     = 0;
    int grant_pulses    = 0;
    int secured_pulses  = 0;

    // One wake of the controller; returns the result it must produce.
    function automatic t_bolt_report advance_bolt(input logic act, input logic trust,
                                                  input logic signed [rmhl_pkg::RANGE_W-1:0] cm,
                                                  input logic [rmhl_pkg::TIME_W-1:0] now);
        t_bolt_report                r;
        int                          srt [rmhl_pkg::WINDOW_LEN];
        int                          med;
        int                          v;
        int                          j;
        logic [rmhl_pkg::TIME_W-1:0] quiet;
        r   = '0;
        med = 0;
        if (act) begin
            last_active_ms = now;
        end
        if (act && trust) begin
            if (!peer_present) begin
                r.grant      = 1'b1;
                peer_present = 1'b1;
            end
            if (ring_pos >= rmhl_pkg::WINDOW_LEN) begin
                ring_pos = 0;
            end
            ring_cm[ring_pos] = cm;
            ring_pos = (ring_pos + 1) % rmhl_pkg::WINDOW_LEN;
            if (ring_fill < rmhl_pkg::WINDOW_LEN) begin
                ring_fill++;
            end
            // upper median of the filled entries only
            for (int i = 0; i < ring_fill; i++) begin
                srt[i] = ring_cm[i];
            end
            for (int i = 1; i < ring_fill; i++) begin
                v = srt[i];
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            med = srt[ring_fill / 2];

            // signed median against unsigned thresholds: negatives are near
            if (med <= int'(shadow_cfg.unlock_thr)) begin
                far_run = 0;
                if (ctl_locked) begin
                    near_run = (near_run >= int'(rmhl_pkg::CNT_MAX)) ?
                               int'(rmhl_pkg::CNT_MAX) : near_run + 1;
                    if (near_run >= int'(shadow_cfg.near_need)) begin
                        r.drive_unlock = 1'b1;
                        ctl_locked     = 1'b0;
                    end
                end
            end else if (med >= int'(shadow_cfg.relock_thr)) begin
                near_run = 0;
                if (!ctl_locked) begin
                    far_run = (far_run >= int'(rmhl_pkg::CNT_MAX)) ?
                              int'(rmhl_pkg::CNT_MAX) : far_run + 1;
                    if (far_run >= int'(shadow_cfg.far_need)) begin
                        r.drive_lock = 1'b1;
                        ctl_locked   = 1'b1;
                    end
                end
            end else begin
                near_run = 0;
                far_run  = 0;
            end
        end

        // peer gone: silence wraps modulo 2^48, so a plain 48-bit subtract
        quiet = now - last_active_ms;
        if (peer_present && quiet >= rmhl_pkg::TIME_W'(shadow_cfg.peer_gone)) begin
            if (!ctl_locked) begin
                r.drive_lock = 1'b1;
                ctl_locked   = 1'b1;
            end
            r.secured    = 1'b1;
            peer_present = 1'b0;
            ring_fill    = 0;
            ring_pos     = 0;
            near_run     = 0;
            far_run      = 0;
        end

        r.median_cm   = med[rmhl_pkg::RANGE_W-1:0];
        r.bolt_locked = ctl_locked;
        return r;
    endfunction

    function automatic t_script_row wake_row(input logic act, input logic trust,
                                             input logic signed [rmhl_pkg::RANGE_W-1:0] cm,
                                             input logic [rmhl_pkg::TIME_W-1:0] now,
                                             input logic typed, input t_bolt_report want);
        t_script_row row;
        row       = '0;
        row.kind  = ROW_WAKE;
        row.act   = act;
        row.trust = trust;
        row.cm    = cm;
        row.now   = now;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic t_script_row reg_row(input logic [rmhl_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [rmhl_pkg::CFG_DATA_W-1:0] data);
        t_script_row row;
        row          = '0;
        row.kind     = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s wrong, got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Wake transfer, with a random gap ahead of it; valid holds until taken.
    task automatic send_wake(input logic act, input logic trust,
                             input logic signed [rmhl_pkg::RANGE_W-1:0] cm,
                             input logic [rmhl_pkg::TIME_W-1:0] now,
                             output t_bolt_report want);
        int gap;
        gap = 0;
        if (!no_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_activity_seen <= act;
        i_range_trusted <= trust;
        i_range_cm      <= cm;
        i_now_ms        <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        want = advance_bolt(act, trust, cm, now);
        wakes_sent++;
    endtask

    // Register write; valid is left high so writes can go back to back.
    task automatic write_reg(input logic [rmhl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rmhl_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rmhl_pkg::REG_UNLOCK_THR: shadow_cfg.unlock_thr = data[rmhl_pkg::THR_W-1:0];
            rmhl_pkg::REG_RELOCK_THR: shadow_cfg.relock_thr = data[rmhl_pkg::THR_W-1:0];
            rmhl_pkg::REG_NEAR_NEED:  shadow_cfg.near_need  = data[rmhl_pkg::DWELL_W-1:0];
            rmhl_pkg::REG_FAR_NEED:   shadow_cfg.far_need   = data[rmhl_pkg::DWELL_W-1:0];
            rmhl_pkg::REG_PEER_GONE:  shadow_cfg.peer_gone  = data[rmhl_pkg::GONE_W-1:0];
            default: ;
        endcase
    endtask

    // Drop both request lines, let every awaited result come out, then let the
    // pipe run dry before anything touches the registers.
    task automatic settle_bolt();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, every transfer checked in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : report_sink
        t_bolt_report seen;
        t_bolt_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen.drive_unlock = o_drive_unlock;
                seen.drive_lock   = o_drive_lock;
                seen.grant        = o_grant_notify;
                seen.secured      = o_secured_notify;
                seen.median_cm    = o_median_cm;
                seen.bolt_locked  = o_bolt_locked;
                unlock_pulses  += seen.drive_unlock;
                lock_pulses    += seen.drive_lock;
                grant_pulses   += seen.grant;
                secured_pulses += seen.secured;
                if (awaited_reports.size() == 0) begin
                    flag_mismatch("result with nothing awaited", 1, 0);
                end else begin
                    want = awaited_reports.pop_front();
                    reports_checked++;
                    if (seen.drive_unlock !== want.drive_unlock)
                        flag_mismatch("drive_unlock", seen.drive_unlock, want.drive_unlock);
                    if (seen.drive_lock !== want.drive_lock)
                        flag_mismatch("drive_lock", seen.drive_lock, want.drive_lock);
                    if (seen.grant !== want.grant)
                        flag_mismatch("grant_notify", seen.grant, want.grant);
                    if (seen.secured !== want.secured)
                        flag_mismatch("secured_notify", seen.secured, want.secured);
                    if (seen.median_cm !== want.median_cm)
                        flag_mismatch("median_cm", int'(seen.median_cm), int'(want.median_cm));
                    if (seen.bolt_locked !== want.bolt_locked)
                        flag_mismatch("bolt_locked", seen.bolt_locked, want.bolt_locked);
                end
            end
            i_out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_script_row                         opening[$];
        t_bolt_report                        want;
        rmhl_pkg::t_cfg                      plan;
        logic [rmhl_pkg::TIME_W-1:0]         clock_ms;
        logic signed [rmhl_pkg::RANGE_W-1:0] cm_bits;
        logic [31:0]                         rnd;
        logic [31:0]                         rnd2;
        logic                                act;
        logic                                trust;
        t_zone                               zone;
        int                                  zone_left;
        int                                  pick;
        int                                  cm;
        int                                  lo;
        int                                  hi;
        int                                  gone;

        // shadow state out of reset
        shadow_cfg     = '{rmhl_pkg::UNLOCK_THR_RST, rmhl_pkg::RELOCK_THR_RST,
                           rmhl_pkg::NEAR_NEED_RST, rmhl_pkg::FAR_NEED_RST,
                           rmhl_pkg::PEER_GONE_RST};
        ctl_locked     = 1'b1;
        peer_present   = 1'b0;
        ring_fill      = 0;
        ring_pos       = 0;
        near_run       = 0;
        far_run        = 0;
        last_active_ms = '0;

        // Directed opening. Typed answers only where they are obvious; the rest
        // go through the shadow model.
        // idle wake straight after reset: bolt locked, nothing else
        opening.push_back(wake_row(1'b0, 1'b0, 16'sd0, 48'd0, 1'b1,
                                   t_bolt_report'{1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b1}));
        // first trusted range of an approach raises grant
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd50, 48'd10, 1'b1,
                                   t_bolt_report'{1'b0, 1'b0, 1'b1, 1'b0, 16'sd50, 1'b1}));
        // second near median meets the default dwell of two: unlock
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd60, 48'd20, 1'b1,
                                   t_bolt_report'{1'b1, 1'b0, 1'b0, 1'b0, 16'sd60, 1'b0}));
        // active but untrusted: range ignored, median reads zero
        opening.push_back(wake_row(1'b1, 1'b0, 16'sh7FFF, 48'd30, 1'b1,
                                   t_bolt_report'{1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0}));
        // far run of three relocks; the last one wraps the ring
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd300, 48'd40, 1'b0, '0));
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd400, 48'd50, 1'b0, '0));
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd500, 48'd60, 1'b0, '0));
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd600, 48'd70, 1'b0, '0));
        // silent for exactly the timeout, trust without activity ignored: secured
        opening.push_back(wake_row(1'b0, 1'b1, -16'sd1, 48'd1570, 1'b1,
                                   t_bolt_report'{1'b0, 1'b0, 1'b0, 1'b1, 16'sd0, 1'b1}));
        // range extremes; the most negative value counts as near
        opening.push_back(wake_row(1'b1, 1'b1, 16'sh8000, 48'd1600, 1'b0, '0));
        opening.push_back(wake_row(1'b1, 1'b1, 16'sh7FFF, 48'd1601, 1'b0, '0));
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd200, 48'd1602, 1'b0, '0));
        // time wraps past 2^48: silence is measured modulo the counter width
        opening.push_back(wake_row(1'b1, 1'b0, 16'sd0, 48'hFFFF_FFFF_FFF0, 1'b0, '0));
        opening.push_back(wake_row(1'b0, 1'b0, 16'sd0, 48'd5, 1'b0, '0));
        opening.push_back(wake_row(1'b0, 1'b0, 16'sd0, 48'd1484, 1'b1,
                                   t_bolt_report'{1'b0, 1'b0, 1'b0, 1'b1, 16'sd0, 1'b1}));
        // zero dwell, zero timeout, top threshold, stray upper data bits,
        // and a write to a hole in the register map
        opening.push_back(reg_row(rmhl_pkg::REG_NEAR_NEED,  16'hFFF0));
        opening.push_back(reg_row(rmhl_pkg::REG_PEER_GONE,  16'h0000));
        opening.push_back(reg_row(rmhl_pkg::REG_UNLOCK_THR, 16'hFFFF));
        opening.push_back(reg_row(REG_SPARE_HI,             16'h0001));
        // everything at once: grant, unlock, relock and secured in one wake
        opening.push_back(wake_row(1'b1, 1'b1, 16'sd5, 48'd2000, 1'b1,
                                   t_bolt_report'{1'b1, 1'b1, 1'b1, 1'b1, 16'sd5, 1'b1}));
        opening.push_back(reg_row(rmhl_pkg::REG_FAR_NEED,   16'hFFFF));
        opening.push_back(reg_row(rmhl_pkg::REG_RELOCK_THR, 16'h0000));
        // no peer any more: a quiet wake stays quiet even with zero timeout
        opening.push_back(wake_row(1'b0, 1'b0, 16'sd0, 48'd2001, 1'b1,
                                   t_bolt_report'{1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b1}));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[k]) begin
            if (opening[k].kind == ROW_REG) begin
                settle_bolt();
                write_reg(opening[k].reg_idx, opening[k].reg_data);
                settle_bolt();
            end else begin
                send_wake(opening[k].act, opening[k].trust, opening[k].cm,
                          opening[k].now, want);
                awaited_reports.push_back(opening[k].typed ? opening[k].want : want);
            end
        end

        // Random part: one register setting per phase, then approaches built
        // from runs of near / far / dead-band ranges, with noise mixed in.
        clock_ms  = 48'd3000;
        zone      = ZONE_NEAR;
        zone_left = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: plan = '{rmhl_pkg::UNLOCK_THR_RST, rmhl_pkg::RELOCK_THR_RST,
                            rmhl_pkg::NEAR_NEED_RST, rmhl_pkg::FAR_NEED_RST,
                            rmhl_pkg::PEER_GONE_RST};
                1: plan = '{15'd0, 15'd1, 4'd1, 4'd1, 16'd1};             // tightest
                2: plan = '{15'h7FFF, 15'h7FFF, 4'd15, 4'd15, 16'hFFFF};  // widest
                3: plan = '{15'd300, 15'd600, 4'd0, 4'd0, 16'd0};         // zero dwell / timeout
                default: begin
                    plan.unlock_thr = rmhl_pkg::THR_W'($urandom_range(0, 1000));
                    plan.relock_thr = plan.unlock_thr +
                                      rmhl_pkg::THR_W'($urandom_range(0, 1000));
                    plan.near_need  = rmhl_pkg::DWELL_W'($urandom_range(1, 6));
                    plan.far_need   = rmhl_pkg::DWELL_W'($urandom_range(1, 6));
                    plan.peer_gone  = rmhl_pkg::GONE_W'($urandom_range(20, 4000));
                end
            endcase

            // junk in the unused upper data bits must be dropped
            rnd = $urandom;
            settle_bolt();
            write_reg(rmhl_pkg::REG_UNLOCK_THR, {rnd[0], plan.unlock_thr});
            write_reg(rmhl_pkg::REG_RELOCK_THR, {rnd[1], plan.relock_thr});
            write_reg(rmhl_pkg::REG_NEAR_NEED,  {rnd[13:2], plan.near_need});
            write_reg(rmhl_pkg::REG_FAR_NEED,   {rnd[25:14], plan.far_need});
            write_reg(rmhl_pkg::REG_PEER_GONE,  plan.peer_gone);
            write_reg(rnd[26] ? REG_SPARE_HI : REG_SPARE_LO,
                      rmhl_pkg::CFG_DATA_W'($urandom));
            settle_bolt();
            no_gaps <= (phase == QUIET_PHASE);

            lo   = int'(shadow_cfg.unlock_thr);
            hi   = int'(shadow_cfg.relock_thr);
            gone = int'(shadow_cfg.peer_gone);

            for (int k = 0; k < WAKES_PER_PHASE; k++) begin
                if (zone_left == 0) begin
                    pick      = $urandom_range(99);
                    zone_left = $urandom_range(1, 20);
                    if (pick < 35)      zone = ZONE_NEAR;
                    else if (pick < 70) zone = ZONE_FAR;
                    else if (pick < 85) zone = ZONE_DEAD;
                    else                zone = ZONE_WILD;
                end
                zone_left--;

                rnd = $urandom;
                case (zone)
                    ZONE_NEAR: cm = lo - int'($urandom_range(0, 150));
                    ZONE_FAR:  cm = hi + int'($urandom_range(0, 150));
                    ZONE_DEAD: cm = (hi - lo > 1) ? int'($urandom_range(lo + 1, hi - 1))
                                                  : lo + 1;
                    default:   cm = int'($signed(rnd[15:0]));
                endcase
                if (cm > 32767)  cm = 32767;
                if (cm < -32768) cm = -32768;
                cm_bits = cm[rmhl_pkg::RANGE_W-1:0];

                act   = ($urandom_range(99) < 82);
                trust = ($urandom_range(99) < 85);

                // mostly short steps; now and then long enough for the peer
                // to be gone, or a jump anywhere in the 48-bit range
                pick = $urandom_range(99);
                if (pick < 6) begin
                    clock_ms = clock_ms + rmhl_pkg::TIME_W'(gone) +
                               rmhl_pkg::TIME_W'($urandom_range(0, 3));
                end else if (pick < 9) begin
                    rnd2     = $urandom;
                    clock_ms = {rnd[31:16], rnd2};
                end else begin
                    clock_ms = clock_ms + rmhl_pkg::TIME_W'($urandom_range(0, gone / 6 + 1));
                end

                send_wake(act, trust, cm_bits, clock_ms, want);
                awaited_reports.push_back(want);
            end
        end

        settle_bolt();

        $display("%0d wakes over %0d register settings, %0d results compared",
                 wakes_sent, PHASES + 1, reports_checked);
        $display("pulses seen: unlock %0d, lock %0d, grant %0d, secured %0d",
                 unlock_pulses, lock_pulses, grant_pulses, secured_pulses);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // A correct run ends long before the 5 ms limit.
    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
